### sv/rwr_pkg.sv
// Shared types, codes and default sizes for the reorder window receiver.
// No dependencies; every other file but rwr_ram refers to it by scoped names.
package rwr_pkg;

  // Fixed widths of the channel fields
  localparam int SEQ_NUM_W = 4;
  localparam int PAYLOAD_W = 64;

  // Defaults for the top-level parameters
  localparam int SEQ_BITS_DEF     = 4;
  localparam int WINDOW_DEF       = 8;
  localparam int PAYLOAD_BITS_DEF = 64;

  typedef logic [SEQ_NUM_W-1:0] seq_num_t;
  typedef logic [PAYLOAD_W-1:0] payload_t;

  // Result kinds
  localparam logic KIND_DELIVER = 1'b0;
  localparam logic KIND_ACK     = 1'b1;

  // Controller states
  typedef enum logic {
    ST_IDLE,
    ST_DRAIN
  } rwr_state_t;

  // Status from datapath to controller
  typedef struct packed {
    logic in_valid;   // packet offered
    logic in_ok;      // checksum good
    logic in_match;   // packet carries the expected number
    logic win_free;   // inside the window and its slot is free
    logic occ_exp;    // slot of the expected number is occupied
    logic out_free;   // output register can take a result
  } rwr_status_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic in_ready;   // take a packet this cycle
    logic load_in;    // deliver the arriving payload
    logic load_mem;   // deliver the buffered payload of the expected slot
    logic load_ack;   // emit the ack
    logic advance;    // free the expected slot and step the expected number
    logic store;      // buffer the arriving packet in its slot
  } rwr_cmd_t;

endpackage

### sv/rwr_if.sv
// Handshake channel interfaces for packets in and results out.
// Depends on rwr_pkg for the field types.
interface rwr_in_if;
  logic              valid;
  logic              ready;
  rwr_pkg::seq_num_t seq_num;
  logic              checksum_ok;
  rwr_pkg::payload_t payload;

  modport source (output valid, output seq_num, output checksum_ok, output payload,
                  input ready);
  modport sink   (input valid, input seq_num, input checksum_ok, input payload,
                  output ready);
endinterface

interface rwr_out_if;
  logic              valid;
  logic              ready;
  logic              kind;
  rwr_pkg::payload_t delivered_payload;
  rwr_pkg::seq_num_t ack_num;
  logic              last;

  modport source (output valid, output kind, output delivered_payload, output ack_num,
                  output last, input ready);
  modport sink   (input valid, input kind, input delivered_payload, input ack_num,
                  input last, output ready);
endinterface

### sv/reorder_window_receiver.sv
// A packet's first result enters the single output register as the packet is taken and
// is on out_ch in the cycle after. A packet yielding n deliveries gives n+1 results, one
// per cycle while out_ch is ready; corrupt and out-of-order packets need no drain, and no
// packet is taken in a drain; it reads one entry per free cycle, ahead of its delivery.
// Reset (rst_n low, synchronous): expected number zero, all slots free, no result pending.
module reorder_window_receiver #(
  parameter int SEQ_BITS     = rwr_pkg::SEQ_BITS_DEF,
  parameter int WINDOW       = rwr_pkg::WINDOW_DEF,
  parameter int PAYLOAD_BITS = rwr_pkg::PAYLOAD_BITS_DEF
) (
  input logic       clk,
  input logic       rst_n,
  rwr_in_if.sink    in_ch,
  rwr_out_if.source out_ch
);

  rwr_pkg::rwr_status_t sts;
  rwr_pkg::rwr_cmd_t    cmd;

  rwr_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  rwr_dp #(
    .SEQ_BITS     (SEQ_BITS),
    .WINDOW       (WINDOW),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cmd    (cmd),
    .sts    (sts)
  );

endmodule

### sv/rwr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rwr_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/rwr_ctrl.sv
// Controller state machine: accepts packets and sequences the drain of
// buffered successors. Depends on rwr_pkg (state, status and command types).
module rwr_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rwr_pkg::rwr_status_t sts,
  output rwr_pkg::rwr_cmd_t    cmd
);

  rwr_pkg::rwr_state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rwr_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      rwr_pkg::ST_IDLE: begin
        cmd.in_ready = sts.out_free;
        if (sts.in_valid && sts.out_free && sts.in_ok) begin
          if (sts.in_match) begin
            // in-order: hand it up at once, then walk the buffer
            cmd.load_in = 1'b1;
            cmd.advance = 1'b1;
            state_nxt   = rwr_pkg::ST_DRAIN;
          end else begin
            cmd.store    = sts.win_free;
            cmd.load_ack = 1'b1;
          end
        end
      end
      rwr_pkg::ST_DRAIN: begin
        if (sts.out_free) begin
          if (sts.occ_exp) begin
            cmd.load_mem = 1'b1;
            cmd.advance  = 1'b1;
          end else begin
            cmd.load_ack = 1'b1;
            state_nxt    = rwr_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = rwr_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

### sv/rwr_dp.sv
// Datapath: expected number, occupancy flags, payload buffer and the output
// register. Depends on rwr_pkg, rwr_if and rwr_ram.
module rwr_dp #(
  parameter int SEQ_BITS     = rwr_pkg::SEQ_BITS_DEF,
  parameter int WINDOW       = rwr_pkg::WINDOW_DEF,
  parameter int PAYLOAD_BITS = rwr_pkg::PAYLOAD_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  rwr_in_if.sink               in_ch,
  rwr_out_if.source            out_ch,
  input  rwr_pkg::rwr_cmd_t    cmd,
  output rwr_pkg::rwr_status_t sts
);

  localparam int SLOTS = 1 << SEQ_BITS;

  logic [SEQ_BITS-1:0]     seq_in;
  logic [PAYLOAD_BITS-1:0] pay_in;
  logic [SEQ_BITS-1:0]     seq_ahead;
  logic [SEQ_BITS-1:0]     expected_r, expected_nxt;
  logic [SLOTS-1:0]        occ_r;
  logic [PAYLOAD_BITS-1:0] ram_rdata;
  logic                    out_valid_r;
  logic                    out_kind_r;
  rwr_pkg::payload_t       out_payload_r;
  rwr_pkg::seq_num_t       out_ack_r;
  logic                    out_last_r;

  // Field extraction: low bits only
  assign seq_in    = SEQ_BITS'(in_ch.seq_num);
  assign pay_in    = PAYLOAD_BITS'(in_ch.payload);
  assign seq_ahead = seq_in - expected_r;

  // Status to the controller
  assign sts.in_valid = in_ch.valid;
  assign sts.in_ok    = in_ch.checksum_ok;
  assign sts.in_match = (seq_in == expected_r);
  assign sts.win_free = (int'(seq_ahead) < WINDOW) && !occ_r[seq_in];
  assign sts.occ_exp  = occ_r[expected_r];
  assign sts.out_free = !out_valid_r || out_ch.ready;

  assign in_ch.ready = cmd.in_ready;

  // Expected number; buffer read runs one step ahead of it
  assign expected_nxt = cmd.advance ? expected_r + 1'b1 : expected_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expected_r <= '0;
    end else begin
      expected_r <= expected_nxt;
    end
  end

  // Occupancy flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else begin
      if (cmd.advance) begin
        occ_r[expected_r] <= 1'b0;
      end
      if (cmd.store) begin
        occ_r[seq_in] <= 1'b1;
      end
    end
  end

  // Payload buffer
  rwr_ram #(
    .WIDTH (PAYLOAD_BITS),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.store),
    .waddr (seq_in),
    .wdata (pay_in),
    .raddr (expected_nxt),
    .rdata (ram_rdata)
  );

  // Output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_in || cmd.load_mem || cmd.load_ack) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (cmd.load_in || cmd.load_mem) begin
      out_kind_r    <= rwr_pkg::KIND_DELIVER;
      out_payload_r <= cmd.load_in ? rwr_pkg::payload_t'(pay_in)
                                   : rwr_pkg::payload_t'(ram_rdata);
      out_ack_r     <= '0;
      out_last_r    <= 1'b0;
    end else if (cmd.load_ack) begin
      out_kind_r    <= rwr_pkg::KIND_ACK;
      out_payload_r <= '0;
      // ack carries the number after any advance in this cycle
      out_ack_r     <= rwr_pkg::seq_num_t'(expected_nxt);
      out_last_r    <= 1'b1;
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.kind              = out_kind_r;
  assign out_ch.delivered_payload = out_payload_r;
  assign out_ch.ack_num           = out_ack_r;
  assign out_ch.last              = out_last_r;

`ifndef SYNTHESIS
  // At most one result loaded per cycle
  a_one_load: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load_in, cmd.load_mem, cmd.load_ack}))
    else $error("two results loaded in one cycle");

  // A delivered slot is free afterwards
  a_slot_freed: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.advance |=> !occ_r[$past(expected_r)])
    else $error("delivered slot still occupied");

  // Buffering never targets the expected slot
  a_store_not_expected: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.store |-> (seq_in != expected_r))
    else $error("store into expected slot");

  // Every delivery steps the expected number
  a_deliver_advances: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load_in || cmd.load_mem) |-> cmd.advance)
    else $error("delivery without advance");
`endif

endmodule

### test/reorder_window_receiver_test.sv
// Self-checking testbench for reorder_window_receiver: directed packet table, then random traffic.
// Depends on rwr_pkg, the rwr_in_if / rwr_out_if channels and the receiver RTL.
`timescale 1ns / 1ps

module reorder_window_receiver_test;

  localparam int SEQ_MOD     = 1 << rwr_pkg::SEQ_BITS_DEF;
  localparam int N_RANDOM    = 78;
  localparam int HOLD_CYCLES = 80;
  localparam int MAX_GAP     = 6;

  // How a directed row is checked
  typedef enum logic [1:0] {
    CHK_PRED,         // expectations come from the predictor
    CHK_NONE,         // dropped, nothing comes out
    CHK_ACK,          // a lone ack with the given number
    CHK_DELIVER_ACK   // the row's own payload, then the ack
  } row_check_t;

  typedef struct packed {
    rwr_pkg::seq_num_t seq;
    logic              ok;
    rwr_pkg::payload_t payload;
    row_check_t        check;
    rwr_pkg::seq_num_t ack;
  } pkt_row_t;

  typedef struct packed {
    logic              kind;
    rwr_pkg::payload_t payload;
    rwr_pkg::seq_num_t ack;
    logic              last;
  } rx_result_t;

  // Directed packets, starting from the reset state (expected number 0)
  localparam int N_DIRECTED = 22;
  pkt_row_t pkt_table [N_DIRECTED] = '{
    '{4'd0,  1'b1, 64'h0000_0000_0000_0000, CHK_DELIVER_ACK, 4'd1},
    '{4'd1,  1'b1, 64'hFFFF_FFFF_FFFF_FFFF, CHK_DELIVER_ACK, 4'd2},
    '{4'd2,  1'b0, 64'h0123_4567_89AB_CDEF, CHK_NONE,        4'd0},  // corrupt
    '{4'd3,  1'b1, 64'h3333_3333_3333_3333, CHK_ACK,         4'd2},
    '{4'd3,  1'b1, 64'hDEAD_BEEF_DEAD_BEEF, CHK_ACK,         4'd2},  // slot taken, kept
    '{4'd9,  1'b1, 64'h9999_0000_9999_0000, CHK_ACK,         4'd2},  // window edge
    '{4'd10, 1'b1, 64'hAAAA_AAAA_AAAA_AAAA, CHK_ACK,         4'd2},  // just outside
    '{4'd1,  1'b1, 64'h1111_1111_1111_1111, CHK_ACK,         4'd2},  // behind
    '{4'd4,  1'b1, 64'h4444_0000_0000_4444, CHK_ACK,         4'd2},
    '{4'd5,  1'b1, 64'h5555_0000_0000_5555, CHK_ACK,         4'd2},
    '{4'd6,  1'b1, 64'h6666_0000_0000_6666, CHK_ACK,         4'd2},
    '{4'd7,  1'b1, 64'h7777_0000_0000_7777, CHK_ACK,         4'd2},
    '{4'd8,  1'b1, 64'h8888_0000_0000_8888, CHK_ACK,         4'd2},
    '{4'd2,  1'b1, 64'h2222_2222_2222_2222, CHK_PRED,        4'd0},  // full drain
    '{4'd15, 1'b0, 64'hF0F0_F0F0_F0F0_F0F0, CHK_NONE,        4'd0},
    '{4'd15, 1'b1, 64'hFFFF_0000_FFFF_0000, CHK_ACK,         4'd10},
    '{4'd10, 1'b1, 64'h8000_0000_0000_0001, CHK_DELIVER_ACK, 4'd11},
    '{4'd12, 1'b1, 64'hCCCC_CCCC_0000_0000, CHK_ACK,         4'd11},
    '{4'd13, 1'b1, 64'h0000_0000_DDDD_DDDD, CHK_ACK,         4'd11},
    '{4'd14, 1'b1, 64'hEEEE_1234_5678_EEEE, CHK_ACK,         4'd11},
    '{4'd11, 1'b1, 64'hBBBB_BBBB_BBBB_BBBB, CHK_PRED,        4'd0},  // drain with wrap
    '{4'd0,  1'b1, 64'h5555_5555_5555_5555, CHK_DELIVER_ACK, 4'd1}
  };

  logic clk;
  logic rst_n;

  rwr_in_if  in_ch ();
  rwr_out_if out_ch ();

  reorder_window_receiver u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Predictor state
  rwr_pkg::seq_num_t next_seq;
  bit                slot_full [SEQ_MOD];
  rwr_pkg::payload_t slot_data [SEQ_MOD];
  rx_result_t        results_due [$];

  int  err_count;
  int  n_packets;
  int  n_corrupt;
  int  n_delivered;
  int  n_acked;
  int  n_holds;
  bit  no_idle;
  bit  hold_out_req;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit
  initial begin
    #2000000;
    $display("%0t: timeout, %0d results still due", $time, results_due.size());
    $display("Simulation FAILED");
    $finish;
  end

  // Receiver model: apply one packet, optionally queue what it produces
  task automatic predict_packet(input rwr_pkg::seq_num_t seq, input logic ok,
                                input rwr_pkg::payload_t pay, input bit push);
    rwr_pkg::seq_num_t ahead;
    int                guard;
    if (!ok) return;
    if (seq == next_seq) begin
      slot_full[seq] = 1'b1;
      slot_data[seq] = pay;
      for (guard = 0; guard < SEQ_MOD && slot_full[next_seq]; guard++) begin
        if (push) begin
          results_due.push_back('{rwr_pkg::KIND_DELIVER, slot_data[next_seq], '0, 1'b0});
        end
        slot_full[next_seq] = 1'b0;
        next_seq = next_seq + 1'b1;
      end
    end else begin
      ahead = seq - next_seq;
      if (ahead < rwr_pkg::WINDOW_DEF && !slot_full[seq]) begin
        slot_full[seq] = 1'b1;
        slot_data[seq] = pay;
      end
    end
    if (push) results_due.push_back('{rwr_pkg::KIND_ACK, '0, next_seq, 1'b1});
  endtask

  // Put one packet on the input channel and return at the edge it is taken
  task automatic offer_packet(input rwr_pkg::seq_num_t seq, input logic ok,
                              input rwr_pkg::payload_t pay);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.seq_num     <= seq;
    in_ch.checksum_ok <= ok;
    in_ch.payload     <= pay;
    do @(posedge clk); while (!in_ch.ready);
    n_packets++;
    if (!ok) n_corrupt++;
  endtask

  // Result side backpressure, with one long hold-off on request
  initial begin
    int gap;
    forever begin
      if (hold_out_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_out_req = 1'b0;
        n_holds++;
      end
      gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  // Result checker
  always @(posedge clk) begin
    rx_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (results_due.size() == 0) begin
        $display("%0t: unexpected result kind=%0b payload=%h ack=%0d last=%0b", $time,
                 out_ch.kind, out_ch.delivered_payload, out_ch.ack_num, out_ch.last);
        err_count++;
      end else begin
        want = results_due.pop_front();
        if (out_ch.kind !== want.kind) begin
          $display("%0t: kind expected %0b got %0b", $time, want.kind, out_ch.kind);
          err_count++;
        end
        if (out_ch.delivered_payload !== want.payload) begin
          $display("%0t: payload expected %h got %h", $time, want.payload,
                   out_ch.delivered_payload);
          err_count++;
        end
        if (out_ch.ack_num !== want.ack) begin
          $display("%0t: ack_num expected %0d got %0d", $time, want.ack, out_ch.ack_num);
          err_count++;
        end
        if (out_ch.last !== want.last) begin
          $display("%0t: last expected %0b got %0b", $time, want.last, out_ch.last);
          err_count++;
        end
        if (want.kind == rwr_pkg::KIND_ACK) n_acked++;
        else n_delivered++;
      end
    end
  end

  // Stimulus
  initial begin
    rwr_pkg::seq_num_t seq;
    logic              ok;
    rwr_pkg::payload_t pay;
    int                pick;
    int                i;
    int                wait_cycles;

    err_count    = 0;
    n_packets    = 0;
    n_corrupt    = 0;
    n_delivered  = 0;
    n_acked      = 0;
    n_holds      = 0;
    no_idle      = 1'b0;
    hold_out_req = 1'b0;
    next_seq     = '0;
    for (i = 0; i < SEQ_MOD; i++) slot_full[i] = 1'b0;

    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.seq_num     <= '0;
    in_ch.checksum_ok <= 1'b0;
    in_ch.payload     <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table
    for (i = 0; i < N_DIRECTED; i++) begin
      offer_packet(pkt_table[i].seq, pkt_table[i].ok, pkt_table[i].payload);
      case (pkt_table[i].check)
        CHK_PRED: begin
          predict_packet(pkt_table[i].seq, pkt_table[i].ok, pkt_table[i].payload, 1'b1);
        end
        CHK_NONE: begin
          predict_packet(pkt_table[i].seq, pkt_table[i].ok, pkt_table[i].payload, 1'b0);
        end
        CHK_ACK: begin
          predict_packet(pkt_table[i].seq, pkt_table[i].ok, pkt_table[i].payload, 1'b0);
          results_due.push_back('{rwr_pkg::KIND_ACK, '0, pkt_table[i].ack, 1'b1});
        end
        default: begin
          predict_packet(pkt_table[i].seq, pkt_table[i].ok, pkt_table[i].payload, 1'b0);
          results_due.push_back('{rwr_pkg::KIND_DELIVER, pkt_table[i].payload, '0, 1'b0});
          results_due.push_back('{rwr_pkg::KIND_ACK, '0, pkt_table[i].ack, 1'b1});
        end
      endcase
    end

    // Random traffic, mostly inside the window so buffers fill and drain
    for (i = 0; i < N_RANDOM; i++) begin
      no_idle = (i >= 30 && i < 45) || (i >= 60 && i < 76);
      if (i == 60) hold_out_req = 1'b1;  // long output stall while packets keep coming
      pick = $urandom_range(0, 99);
      pay  = {$urandom, $urandom};
      ok   = 1'b1;
      if (pick < 10) begin
        seq = rwr_pkg::seq_num_t'($urandom_range(0, SEQ_MOD - 1));
        ok  = 1'b0;
      end else if (pick < 35) begin
        seq = next_seq;
      end else if (pick < 85) begin
        seq = next_seq + rwr_pkg::seq_num_t'($urandom_range(1, rwr_pkg::WINDOW_DEF - 1));
      end else begin
        seq = rwr_pkg::seq_num_t'($urandom_range(0, SEQ_MOD - 1));
      end
      offer_packet(seq, ok, pay);
      predict_packet(seq, ok, pay, 1'b1);
    end
    in_ch.valid <= 1'b0;
    no_idle = 1'b0;

    // Drain, then a short quiet tail
    while (results_due.size() != 0) @(posedge clk);
    wait_cycles = 0;
    while (wait_cycles < 10) begin
      @(posedge clk);
      wait_cycles++;
    end

    $display("Sent %0d packets (%0d corrupt), %0d output hold-off(s)", n_packets, n_corrupt,
             n_holds);
    $display("Checked %0d deliveries and %0d acks", n_delivered, n_acked);
    if (err_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### sim.f
sv/rwr_pkg.sv
sv/rwr_if.sv
sv/rwr_ram.sv
sv/rwr_ctrl.sv
sv/rwr_dp.sv
sv/reorder_window_receiver.sv
test/reorder_window_receiver_test.sv
